// ===== src/ccma_pkg.sv =====
// Shared types and constants of the class-conditioned mean accumulator.
// No dependencies; every other file imports this package.
package ccma_pkg;

  // Input item word
  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  lane;
    logic [7:0]  data_byte;
    logic [5:0]  set_index;
    logic [15:0] timing;
  } in_t;

  // Result word
  typedef struct packed {
    logic signed [19:0] mean_offset;
    logic [55:0]        square_sum;
    logic [31:0]        record_count;
    logic               status;
  } out_t;

  // Item operations; the unused code is dropped at the front
  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_ACCUM = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Configuration register indexes
  localparam logic CFG_CLASS_MASK   = 1'b0;
  localparam logic CFG_SAMPLE_LIMIT = 1'b1;
  localparam int   CfgDataW         = 16;
  localparam logic [7:0]  ClassMaskReset   = 8'd255;
  localparam logic [15:0] SampleLimitReset = 16'd400;

  // Classified command passed from front to back
  typedef struct packed {
    op_e         op;
    logic        ok;
    logic [3:0]  lane;
    logic [7:0]  cls;
    logic [5:0]  set_idx;
    logic [15:0] val;
  } cmd_t;

  localparam int CmdqDepth = 2;

  // Divider geometry: numerator is sum*1000 + count/2
  localparam int NumW = 66;
  localparam int DenW = 40;

  // Store widths
  localparam int CntW  = 32;
  localparam int TotW  = 40;
  localparam int SumW  = 48;
  localparam int SqW   = 56;

  // Scaled mean cap and offset limits
  localparam logic [63:0]        MeanCap = 64'd9007199254740992000;
  localparam logic signed [64:0] OffMax  = 65'sd524287;
  localparam logic signed [64:0] OffMin  = -65'sd524288;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIV_A,
    ST_DIV_B,
    ST_DIFF
  } back_state_e;

endpackage

// ===== src/ccma_front.sv =====
// Front end: configuration registers, class masking, clamping, range checks.
// Depends on ccma_pkg.
module ccma_front import ccma_pkg::*; #(
  parameter int LANES   = 16,
  parameter int SETS    = 64,
  parameter int CLASSES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                accept_i,
  input  in_t                 item_i,
  output logic                cmd_valid_o,
  output cmd_t                cmd_o
);

  logic [7:0]  class_mask_q;
  logic [15:0] sample_limit_q;
  logic [7:0]  cls;
  logic        lane_ok, cls_ok, set_ok;

  // Hold configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_mask_q   <= ClassMaskReset;
      sample_limit_q <= SampleLimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CLASS_MASK:   class_mask_q   <= cfg_data_i[7:0];
        CFG_SAMPLE_LIMIT: sample_limit_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Classify the item
  always_comb begin
    cls     = item_i.data_byte & class_mask_q;
    lane_ok = int'(item_i.lane) < LANES;
    cls_ok  = int'(cls) < CLASSES;
    set_ok  = int'(item_i.set_index) < SETS;
    cmd_valid_o   = accept_i && (item_i.mode != OP_NONE);
    cmd_o.op      = op_e'(item_i.mode);
    cmd_o.ok      = (item_i.mode == OP_COUNT) ? (lane_ok && cls_ok)
                                              : (lane_ok && cls_ok && set_ok);
    cmd_o.lane    = item_i.lane;
    cmd_o.cls     = cls;
    cmd_o.set_idx = item_i.set_index;
    cmd_o.val     = (item_i.timing > sample_limit_q) ? sample_limit_q : item_i.timing;
  end

endmodule

// ===== src/ccma_cmdq.sv =====
// Short command queue between front and back ends.
// Depends on ccma_pkg.
module ccma_cmdq import ccma_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t data_o
);

  localparam int PtrW = (CmdqDepth > 1) ? $clog2(CmdqDepth) : 1;
  localparam int CntQW = $clog2(CmdqDepth + 1);

  cmd_t             slot_q [CmdqDepth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntQW-1:0] cnt_q;

  assign full_o  = (int'(cnt_q) == CmdqDepth);
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_q];

  // Store pushed words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (int'(wr_q) == CmdqDepth - 1) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (int'(rd_q) == CmdqDepth - 1) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/ccma_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on ccma_pkg.
module ccma_div import ccma_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);

  localparam int StepW = $clog2(NumW + 1);

  logic             busy_q, done_q;
  logic [StepW-1:0] step_q;
  logic [DenW:0]    rem_q, rem_sh, rem_sub;
  logic [NumW-1:0]  quo_q;
  logic [DenW-1:0]  den_q;
  logic             take;

  assign done_o = done_q;
  assign quot_o = quo_q;

  // Trial subtract
  always_comb begin
    rem_sh  = {rem_q[DenW-1:0], quo_q[NumW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    take    = rem_sh >= {1'b0, den_q};
  end

  // Shift one bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= take ? rem_sub : rem_sh;
      quo_q <= {quo_q[NumW-2:0], take};
    end
  end

  // Step counter and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (int'(step_q) == NumW - 1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/ccma_back.sv =====
// Back end: statistic stores, clearing pass, update and query sequencer.
// Depends on ccma_pkg and ccma_div.
module ccma_back import ccma_pkg::*; #(
  parameter int LANES   = 16,
  parameter int SETS    = 64,
  parameter int CLASSES = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic clearing_o,
  input  logic res_pop_i,
  output logic res_valid_o,
  output out_t res_o
);

  localparam int CcDepth = LANES * CLASSES;
  localparam int SsDepth = CcDepth * SETS;
  localparam int LsDepth = LANES * SETS;
  localparam int CcW = $clog2(CcDepth);
  localparam int SsW = $clog2(SsDepth);
  localparam int LsW = (LsDepth > 1) ? $clog2(LsDepth) : 1;
  localparam int LiW = (LANES > 1) ? $clog2(LANES) : 1;

  back_state_e st_q, st_d;

  logic [CntW-1:0] cc_mem [CcDepth];
  logic [SumW-1:0] ss_mem [SsDepth];
  logic [SqW-1:0]  sq_mem [SsDepth];
  logic [SqW-1:0]  ls_mem [LsDepth];
  logic [TotW-1:0] ltc_q  [LANES];

  logic [SsW-1:0]  clr_q;
  cmd_t            cmd_q;
  logic [CcW-1:0]  ci_d, ci_q;
  logic [SsW-1:0]  si_d, si_q;
  logic [LsW-1:0]  li_d, li_q;
  logic [LiW-1:0]  lane_d, lane_q;

  logic [CntW-1:0] cnt_rd;
  logic [SumW-1:0] sum_rd;
  logic [SqW-1:0]  sq_rd, ls_rd;
  logic [TotW-1:0] tc_q;

  logic            issue, wr_cc, wr_ltc, wr_acc, do_div, div_start, div_done;
  logic            res_direct, res_diff, clr_last;
  logic [SqW-1:0]  div_s;
  logic [DenW-1:0] div_c;
  logic [NumW-1:0] div_num, quot;
  logic            cap_q;
  logic [63:0]     a_q, b_q;
  logic signed [64:0] diff;
  logic [31:0]     vsq;
  logic            res_valid_q;
  out_t            res_q;

  assign clearing_o  = (st_q == ST_CLEAR);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign clr_last    = (int'(clr_q) == SsDepth - 1);

  // Addresses of the queue head
  always_comb begin
    if (cmd_i.ok) begin
      ci_d   = CcW'(int'(cmd_i.lane) * CLASSES + int'(cmd_i.cls));
      si_d   = SsW'((int'(cmd_i.lane) * CLASSES + int'(cmd_i.cls)) * SETS
                    + int'(cmd_i.set_idx));
      li_d   = LsW'(int'(cmd_i.lane) * SETS + int'(cmd_i.set_idx));
      lane_d = LiW'(cmd_i.lane);
    end else begin
      ci_d   = '0;
      si_d   = '0;
      li_d   = '0;
      lane_d = '0;
    end
  end

  // Control decode
  always_comb begin
    issue  = (st_q == ST_IDLE) && cmd_valid_i && !(cmd_i.op == OP_QUERY && res_valid_q);
    wr_cc  = (st_q == ST_READ) && (cmd_q.op == OP_COUNT) && cmd_q.ok && (cnt_rd != '1);
    wr_ltc = wr_cc && (tc_q != '1);
    wr_acc = (st_q == ST_READ) && (cmd_q.op == OP_ACCUM) && cmd_q.ok;
    do_div = (cmd_q.op == OP_QUERY) && cmd_q.ok && (tc_q != '0) && (cnt_rd != '0);
    div_start  = ((st_q == ST_READ) && do_div) || ((st_q == ST_DIV_A) && div_done);
    res_direct = (st_q == ST_READ) && (cmd_q.op == OP_QUERY) && !do_div;
    res_diff   = (st_q == ST_DIFF);
    cmd_pop_o  = issue;
  end

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_CLEAR: if (clr_last) st_d = ST_IDLE;
      ST_IDLE:  if (issue) st_d = ST_READ;
      ST_READ:  st_d = do_div ? ST_DIV_A : ST_IDLE;
      ST_DIV_A: if (div_done) st_d = ST_DIV_B;
      ST_DIV_B: if (div_done) st_d = ST_DIFF;
      ST_DIFF:  st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  // Divider operands: s*1000 + c/2
  always_comb begin
    if (st_q == ST_DIV_A) begin
      div_s = ls_rd;
      div_c = tc_q;
    end else begin
      div_s = SqW'(sum_rd);
      div_c = DenW'(cnt_rd);
    end
    div_num = ({10'b0, div_s} << 10) - ({10'b0, div_s} << 4) - ({10'b0, div_s} << 3)
              + NumW'(div_c >> 1);
  end

  ccma_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_c),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Offset and square term
  always_comb begin
    diff = $signed({1'b0, a_q}) - $signed({1'b0, b_q});
    if (diff > OffMax) begin
      diff = OffMax;
    end else if (diff < OffMin) begin
      diff = OffMin;
    end
    vsq = cmd_q.val * cmd_q.val;
  end

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (res_direct || res_diff) begin
        res_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Latch command, totals and quotients
  always_ff @(posedge clk_i) begin
    if (issue) begin
      cmd_q  <= cmd_i;
      ci_q   <= ci_d;
      si_q   <= si_d;
      li_q   <= li_d;
      lane_q <= lane_d;
      tc_q   <= ltc_q[lane_d];
    end
    if (div_start) begin
      cap_q <= (DenW'(div_s >> 53) >= div_c);
    end
    if (st_q == ST_DIV_A && div_done) begin
      a_q <= cap_q ? MeanCap : quot[63:0];
    end
    if (st_q == ST_DIV_B && div_done) begin
      b_q <= cap_q ? MeanCap : quot[63:0];
    end
    if (res_direct) begin
      res_q.mean_offset  <= '0;
      res_q.square_sum   <= cmd_q.ok ? sq_rd : '0;
      res_q.record_count <= cmd_q.ok ? cnt_rd : '0;
      res_q.status       <= cmd_q.ok ? (tc_q == '0) : 1'b1;
    end else if (res_diff) begin
      res_q.mean_offset  <= diff[19:0];
      res_q.square_sum   <= sq_rd;
      res_q.record_count <= cnt_rd;
      res_q.status       <= 1'b0;
    end
  end

  // Lane record totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANES; i++) begin
        ltc_q[i] <= '0;
      end
    end else if (wr_ltc) begin
      ltc_q[lane_q] <= tc_q + 1'b1;
    end
  end

  // Class count store
  always_ff @(posedge clk_i) begin
    if (st_q == ST_CLEAR && int'(clr_q) < CcDepth) begin
      cc_mem[clr_q[CcW-1:0]] <= '0;
    end else if (wr_cc) begin
      cc_mem[ci_q] <= cnt_rd + 1'b1;
    end
    if (issue) begin
      cnt_rd <= cc_mem[ci_d];
    end
  end

  // Sample sum store
  always_ff @(posedge clk_i) begin
    if (st_q == ST_CLEAR) begin
      ss_mem[clr_q] <= '0;
    end else if (wr_acc) begin
      ss_mem[si_q] <= sum_rd + SumW'(cmd_q.val);
    end
    if (issue) begin
      sum_rd <= ss_mem[si_d];
    end
  end

  // Square sum store
  always_ff @(posedge clk_i) begin
    if (st_q == ST_CLEAR) begin
      sq_mem[clr_q] <= '0;
    end else if (wr_acc) begin
      sq_mem[si_q] <= sq_rd + SqW'(vsq);
    end
    if (issue) begin
      sq_rd <= sq_mem[si_d];
    end
  end

  // Lane per-set total store
  always_ff @(posedge clk_i) begin
    if (st_q == ST_CLEAR && int'(clr_q) < LsDepth) begin
      ls_mem[clr_q[LsW-1:0]] <= '0;
    end else if (wr_acc) begin
      ls_mem[li_q] <= ls_rd + SqW'(cmd_q.val);
    end
    if (issue) begin
      ls_rd <= ls_mem[li_d];
    end
  end

endmodule

// ===== src/class_conditioned_mean_accumulator.sv =====
// Top level of the class-conditioned mean accumulator.
// Depends on ccma_pkg, ccma_front, ccma_cmdq, ccma_back.
//
//   channel   ports                          moves
//   input     push_i, full_o, item_i         in_t word, accepted on push_i && !full_o
//   result    pop_i, empty_o, result_o       out_t word, taken on pop_i && !empty_o
//   config    cfg_we_i, cfg_idx_i, cfg_data_i  register write, no wait
//
// In the back end, count and accumulate words read the stores on issue and write them back in ST_READ.
// A query that needs a mean makes two passes of the shared divider (ST_DIV_A, then ST_DIV_B) before ST_DIFF.
// After reset a clearing pass steps through all LANES*CLASSES*SETS store addresses (262144 at defaults)
// and zeroes the stores; full_o stays high meanwhile.
// The two-entry command queue buffers words; only a query waits at its head while a result waits for pop_i.
module class_conditioned_mean_accumulator import ccma_pkg::*; #(
  parameter int LANES   = 16,
  parameter int SETS    = 64,
  parameter int CLASSES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                push_i,
  output logic                full_o,
  input  in_t                 item_i,
  output logic                empty_o,
  input  logic                pop_i,
  output out_t                result_o
);

  logic cmd_valid, q_full, q_valid, q_pop, clearing, res_valid;
  cmd_t cmd, q_head;

  // Stall input during the clearing pass
  assign full_o  = q_full || clearing;
  assign empty_o = !res_valid;

  ccma_front #(.LANES(LANES), .SETS(SETS), .CLASSES(CLASSES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (push_i && !full_o),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  ccma_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .data_i  (cmd),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_head)
  );

  ccma_back #(.LANES(LANES), .SETS(SETS), .CLASSES(CLASSES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_head),
    .cmd_pop_o   (q_pop),
    .clearing_o  (clearing),
    .res_pop_i   (pop_i && res_valid),
    .res_valid_o (res_valid),
    .res_o       (result_o)
  );

endmodule
